@@ rtl/core/bbsc_pkg.sv @@
// Shared types and constants for the bucket bit-size counter.
// Used by bbsc_gamma_len, bbsc_cost and bucket_bit_size_counter.
package bbsc_pkg;

   typedef enum logic [1:0] {
      CMD_KEY     = 2'd0,
      CMD_VERSION = 2'd1,
      CMD_EMPTY   = 2'd2,
      CMD_UNUSED  = 2'd3
   } cmd_type;

   localparam int unsigned SUFFIX_W  = 64;
   localparam int unsigned VERSION_W = 64;
   localparam int unsigned IDENT_W   = 32;
   localparam int unsigned COUNT_W   = 32;
   localparam int unsigned TOTAL_W   = 32;
   localparam int unsigned CSR_W     = 7;
   localparam int unsigned GLEN_W    = 8;   // gamma length, at most 129
   localparam int unsigned INC_W     = 9;   // two gamma lengths, at most 194

   localparam logic [CSR_W-1:0]   SUFFIX_WIDTH_RESET = 7'd16;
   localparam logic [CSR_W-1:0]   SUFFIX_WIDTH_MAX   = 7'd64;
   localparam logic [GLEN_W-1:0]  HEADER_BITS        = 8'd16;
   localparam logic [GLEN_W-1:0]  FIRST_VERSION_BITS = 8'd96;
   localparam logic [TOTAL_W-1:0] EMPTY_BUCKET_BITS  = 32'd16;

   // Per-bucket history that the next item is measured against.
   typedef struct packed {
      logic [SUFFIX_W-1:0]  prior_suffix;
      logic [VERSION_W-1:0] prev_version;
      logic [IDENT_W-1:0]   prev_ident;
      logic                 first_key_pending;
      logic                 first_version_pending;
   } bucket_state_type;

endpackage

@@ rtl/core/bbsc_gamma_len.sv @@
// Elias-gamma code length of (x + 1), with x + 1 taken at 65 bits.
// Depends on bbsc_pkg for the length width.
module bbsc_gamma_len (
   input  logic [63:0]                  x,
   output logic [bbsc_pkg::GLEN_W-1:0]  len
);

   logic [64:0] m;
   logic [6:0]  msb_idx;

   assign m = {1'b0, x} + 65'd1;

   // Priority search for the top set bit; m is never zero.
   always_comb begin
      msb_idx = 7'd0;
      for (int i = 1; i < 65; i++) begin
         if (m[i]) begin
            msb_idx = 7'(i);
         end
      end
   end

   assign len = {msb_idx, 1'b1};

endmodule

@@ rtl/core/bbsc_cost.sv @@
// Bit cost of one registered item against the bucket history.
// Depends on bbsc_pkg and bbsc_gamma_len.
module bbsc_cost (
   input  bbsc_pkg::cmd_type                  cmd,
   input  logic [bbsc_pkg::SUFFIX_W-1:0]      key_suffix,
   input  logic [bbsc_pkg::COUNT_W-1:0]       version_count,
   input  logic [bbsc_pkg::VERSION_W-1:0]     version_word,
   input  logic [bbsc_pkg::IDENT_W-1:0]       entry_id,
   input  bbsc_pkg::bucket_state_type         hist,
   input  logic [bbsc_pkg::CSR_W-1:0]         suffix_width,
   output logic [bbsc_pkg::INC_W-1:0]         inc,
   output logic                               count_zero
);

   logic [bbsc_pkg::SUFFIX_W-1:0]  suffix_delta;
   logic [bbsc_pkg::VERSION_W-1:0] version_delta;
   logic [bbsc_pkg::IDENT_W-1:0]   ident_delta;
   logic [bbsc_pkg::IDENT_W-1:0]   ident_zz;
   logic [bbsc_pkg::COUNT_W-1:0]   count_m1;
   logic [bbsc_pkg::GLEN_W-1:0]    suffix_len;
   logic [bbsc_pkg::GLEN_W-1:0]    version_len;
   logic [bbsc_pkg::GLEN_W-1:0]    ident_len;
   logic [bbsc_pkg::GLEN_W-1:0]    count_len;
   logic [bbsc_pkg::CSR_W-1:0]     width_clamped;
   logic [bbsc_pkg::GLEN_W-1:0]    part_a;
   logic [bbsc_pkg::GLEN_W-1:0]    part_b;

   assign suffix_delta  = key_suffix - hist.prior_suffix;
   assign version_delta = hist.prev_version - version_word;
   assign ident_delta   = entry_id - hist.prev_ident;
   assign ident_zz      = {ident_delta[bbsc_pkg::IDENT_W-2:0], 1'b0}
                          ^ {bbsc_pkg::IDENT_W{ident_delta[bbsc_pkg::IDENT_W-1]}};
   // gamma(count) is the gamma length of (count - 1) + 1
   assign count_m1      = version_count - 32'd1;
   assign count_zero    = (version_count == '0);

   assign width_clamped = (suffix_width > bbsc_pkg::SUFFIX_WIDTH_MAX)
                          ? bbsc_pkg::SUFFIX_WIDTH_MAX : suffix_width;

   bbsc_gamma_len u_suffix_len (
      .x   (suffix_delta),
      .len (suffix_len)
   );

   bbsc_gamma_len u_version_len (
      .x   (version_delta),
      .len (version_len)
   );

   bbsc_gamma_len u_ident_len (
      .x   ({32'd0, ident_zz}),
      .len (ident_len)
   );

   bbsc_gamma_len u_count_len (
      .x   ({32'd0, count_m1}),
      .len (count_len)
   );

   always_comb begin
      part_a = '0;
      part_b = '0;
      case (cmd)
         bbsc_pkg::CMD_KEY: begin
            part_a = hist.first_key_pending
                     ? bbsc_pkg::HEADER_BITS + {1'b0, width_clamped}
                     : suffix_len;
            part_b = count_zero ? '0 : count_len;
         end
         bbsc_pkg::CMD_VERSION: begin
            part_a = hist.first_version_pending ? bbsc_pkg::FIRST_VERSION_BITS
                                                : version_len;
            part_b = hist.first_version_pending ? '0 : ident_len;
         end
         default: begin
            part_a = '0;
            part_b = '0;
         end
      endcase
   end

   assign inc = {1'b0, part_a} + {1'b0, part_b};

endmodule

@@ rtl/core/bucket_bit_size_counter.sv @@
// Bucket bit-size counter: measures the encoded size of one bucket.
// Items enter on the req_ channel and each is costed against the history of
// the current bucket (previous suffix, version and id). An item with
// req_last set, or an empty-bucket item, closes the bucket and produces one
// beat on the rsp_ channel with the running total and the error flag; every
// other item produces no beat. csr_write_en writes the raw width of the
// first key's suffix (values above 64 count as 64); write it only while idle.
// A closing item passes through the input register and then the result register
// before it is shown on rsp_valid. Throughput: one item every cycle while
// req_stall is low, set by the single cost stage between the input register
// and the result register (a 64-bit subtract, a leading-one search and a
// 32-bit saturating add). When the result register holds an untaken beat,
// items that close no bucket still flow; a closing item waits in the input
// register, and req_stall rises only then. Synchronous reset empties both
// registers, clears the bucket history and sets the suffix width to 16.
// Depends on bbsc_pkg, bbsc_cost and bbsc_gamma_len.
module bucket_bit_size_counter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [63:0] req_key_suffix,
   input  logic [31:0] req_version_count,
   input  logic [63:0] req_version_word,
   input  logic [31:0] req_entry_id,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_total_bits,
   output logic        rsp_error,
   input  logic        csr_write_en,
   input  logic [6:0]  csr_write_data
);

   localparam bbsc_pkg::bucket_state_type HIST_RESET = '{
      prior_suffix:          '0,
      prev_version:          '0,
      prev_ident:            '0,
      first_key_pending:     1'b1,
      first_version_pending: 1'b1
   };

   logic [bbsc_pkg::CSR_W-1:0]     suffix_width_ff;

   logic                           s1_valid_ff, s1_valid_in;
   bbsc_pkg::cmd_type              s1_cmd_ff;
   logic [bbsc_pkg::SUFFIX_W-1:0]  s1_key_ff;
   logic [bbsc_pkg::COUNT_W-1:0]   s1_count_ff;
   logic [bbsc_pkg::VERSION_W-1:0] s1_version_ff;
   logic [bbsc_pkg::IDENT_W-1:0]   s1_ident_ff;
   logic                           s1_last_ff;

   bbsc_pkg::bucket_state_type     hist_ff, hist_in;
   logic [bbsc_pkg::TOTAL_W-1:0]   bit_total_ff, bit_total_in;
   logic                           error_seen_ff, error_seen_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [bbsc_pkg::TOTAL_W-1:0]   rsp_total_ff, rsp_total_in;
   logic                           rsp_error_ff, rsp_error_in;

   logic                           req_accept;
   logic                           rsp_take;
   logic                           s1_closes;
   logic                           s1_advance;
   logic [bbsc_pkg::INC_W-1:0]     inc;
   logic                           count_zero;
   logic [bbsc_pkg::TOTAL_W:0]     sum;
   logic [bbsc_pkg::TOTAL_W-1:0]   total_next;
   logic                           error_next;

   assign rsp_take   = rsp_valid_ff & ~rsp_stall;
   assign s1_closes  = s1_last_ff | (s1_cmd_ff == bbsc_pkg::CMD_EMPTY);
   assign s1_advance = s1_valid_ff & (~s1_closes | ~rsp_valid_ff | ~rsp_stall);
   assign req_stall  = s1_valid_ff & ~s1_advance;
   assign req_accept = req_valid & ~req_stall;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         suffix_width_ff <= bbsc_pkg::SUFFIX_WIDTH_RESET;
      end else if (csr_write_en) begin
         suffix_width_ff <= csr_write_data;
      end
   end

   // Input register
   assign s1_valid_in = req_accept | (s1_valid_ff & ~s1_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff     <= bbsc_pkg::cmd_type'(req_cmd);
         s1_key_ff     <= req_key_suffix;
         s1_count_ff   <= req_version_count;
         s1_version_ff <= req_version_word;
         s1_ident_ff   <= req_entry_id;
         s1_last_ff    <= req_last;
      end
   end

   bbsc_cost u_cost (
      .cmd            (s1_cmd_ff),
      .key_suffix     (s1_key_ff),
      .version_count  (s1_count_ff),
      .version_word   (s1_version_ff),
      .entry_id       (s1_ident_ff),
      .hist           (hist_ff),
      .suffix_width   (suffix_width_ff),
      .inc            (inc),
      .count_zero     (count_zero)
   );

   // Saturating accumulate of the item's cost
   assign sum        = {1'b0, bit_total_ff} + {{(bbsc_pkg::TOTAL_W+1-bbsc_pkg::INC_W){1'b0}}, inc};
   assign total_next = sum[bbsc_pkg::TOTAL_W] ? '1 : sum[bbsc_pkg::TOTAL_W-1:0];
   assign error_next = error_seen_ff | sum[bbsc_pkg::TOTAL_W]
                       | ((s1_cmd_ff == bbsc_pkg::CMD_KEY) & count_zero);

   always_comb begin
      hist_in       = hist_ff;
      bit_total_in  = bit_total_ff;
      error_seen_in = error_seen_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_take;
      rsp_total_in  = rsp_total_ff;
      rsp_error_in  = rsp_error_ff;
      if (s1_advance) begin
         case (s1_cmd_ff)
            bbsc_pkg::CMD_EMPTY: begin
               hist_in       = HIST_RESET;
               bit_total_in  = '0;
               error_seen_in = 1'b0;
               rsp_valid_in  = 1'b1;
               rsp_total_in  = bbsc_pkg::EMPTY_BUCKET_BITS;
               rsp_error_in  = 1'b0;
            end
            bbsc_pkg::CMD_KEY: begin
               hist_in.prior_suffix          = s1_key_ff;
               hist_in.first_key_pending     = 1'b0;
               hist_in.first_version_pending = 1'b1;
               bit_total_in                  = total_next;
               error_seen_in                 = error_next;
            end
            bbsc_pkg::CMD_VERSION: begin
               hist_in.prev_version          = s1_version_ff;
               hist_in.prev_ident            = s1_ident_ff;
               hist_in.first_version_pending = 1'b0;
               bit_total_in                  = total_next;
               error_seen_in                 = error_next;
            end
            default: begin
               // unused command: adds nothing
            end
         endcase
         if (s1_last_ff && (s1_cmd_ff != bbsc_pkg::CMD_EMPTY)) begin
            rsp_valid_in  = 1'b1;
            rsp_total_in  = bit_total_in;
            rsp_error_in  = error_seen_in;
            hist_in       = HIST_RESET;
            bit_total_in  = '0;
            error_seen_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff       <= HIST_RESET;
         bit_total_ff  <= '0;
         error_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hist_ff       <= hist_in;
         bit_total_ff  <= bit_total_in;
         error_seen_ff <= error_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_total_ff <= rsp_total_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_total_bits = rsp_total_ff;
   assign rsp_error      = rsp_error_ff;

`ifndef SYNTH
   a_empty_gives_16: assert property (@(posedge clock) disable iff (reset)
      s1_advance && (s1_cmd_ff == bbsc_pkg::CMD_EMPTY)
      |=> rsp_valid && (rsp_total_bits == bbsc_pkg::EMPTY_BUCKET_BITS) && !rsp_error)
      else $error("empty bucket beat is not 16 bits without error");

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_closes
      |=> (bit_total_ff == '0) && !error_seen_ff && hist_ff.first_key_pending
          && hist_ff.first_version_pending)
      else $error("bucket history not cleared after closing item");

   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      s1_advance && !s1_closes |=> bit_total_ff >= $past(bit_total_ff))
      else $error("running total decreased within a bucket");

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s1_closes && rsp_valid_ff && rsp_stall)
      else $error("input stalled without a blocked closing item");
`endif

endmodule
